FILE: src/msh_pkg.sv
package msh_pkg;
  localparam int Depth = 1024;
  localparam int AddrW = $clog2(Depth);
  localparam int CntW = AddrW + 1;

  typedef enum logic [1:0] {
    ST_OK = 2'd0,
    ST_POP_EMPTY = 2'd1,
    ST_PUSH_FULL = 2'd2
  } status_t;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP = 1'b1;
endpackage

FILE: src/msh_if.sv
interface msh_in_if (input logic clk);
  logic valid;
  logic ready;
  logic operation;
  logic signed [31:0] push_value;
  modport source (output valid, operation, push_value, input ready);
  modport sink (input valid, operation, push_value, output ready);
endinterface

interface msh_out_if (input logic clk);
  logic valid;
  logic ready;
  logic signed [31:0] top_value;
  logic signed [31:0] min_value;
  logic [10:0] entry_total;
  logic is_empty;
  logic [1:0] status;
  modport source (output valid, top_value, min_value, entry_total, is_empty, status,
                  input ready);
  modport sink (input valid, top_value, min_value, entry_total, is_empty, status,
                output ready);
endinterface

FILE: src/msh_ram.sv
module msh_ram #(
  parameter int Width = 32,
  parameter int AddrBits = 10
) (
  input  logic                clk,
  input  logic                we,
  input  logic [AddrBits-1:0] waddr,
  input  logic [Width-1:0]    wdata,
  input  logic [AddrBits-1:0] raddr,
  output logic [Width-1:0]    rdata
);
  logic [Width-1:0] mem [0:(1<<AddrBits)-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: src/min_stack_heap.sv
// min_stack_heap: LIFO stack of signed 32-bit values with a min-heap over
// the same entries, so every result carries both the newest and the
// smallest stored value.
// Channels: in (operation, push_value) and out (top_value, min_value,
// entry_total, is_empty, status), valid/ready, transaction on valid&&ready.
// One result per input transaction; one transaction in flight at a time.
// A push sifts the new entry up the heap; a pop moves the entry from the
// last heap slot into the slot of the removed entry and sifts it up or
// down, unless the removed entry holds the last heap slot. Sifting walks
// at most 9 heap levels for 1024 entries. After the result is taken the
// block returns to idle before it accepts the next transaction. Each level
// reads the heap order and value memories through their single read ports,
// compares (once going up, against each child going down) and writes the swap.
// Status 1 flags a pop on empty (nothing changes), status 2 a push on full.
// Reset clears the entry count and the control; memory contents stay
// undefined, and data read from unwritten entries is never used.
// When the receiver stalls, the result is held in the output register and
// no new transaction is accepted until it is taken.
module min_stack_heap (
  input logic clk,
  input logic rst,
  msh_in_if.sink in,
  msh_out_if.source out
);
  localparam int AW = msh_pkg::AddrW;
  localparam int CW = msh_pkg::CntW;

  typedef enum logic [4:0] {
    S_IDLE, S_PUSH_W, S_POP_RDPOS, S_POP_MOVE, S_POP_MOVE2,
    S_UP_RD, S_UP_RDW, S_UP_PV, S_UP_PVW, S_UP_CMP,
    S_DN_RD, S_DN_RDW, S_DN_L, S_DN_LW, S_DN_R, S_DN_RW, S_DN_CMP,
    S_SWAP, S_SWAP2, S_FIN, S_FIN_W, S_FIN2, S_OUT
  } state_t;

  state_t state;
  logic [CW-1:0] count;
  logic [AW-1:0] cur, oth, lc, best;
  logic [AW-1:0] ent_cur, ent_oth, ent_best;
  logic signed [31:0] val_cur, val_best;
  logic down_mode, moved_up;
  logic [1:0] status;

  // memories
  logic v_we, o_we, p_we;
  logic [AW-1:0] v_wa, o_wa, p_wa, v_ra, o_ra, p_ra;
  logic [31:0] v_wd, v_rd;
  logic [AW-1:0] o_wd, o_rd, p_wd, p_rd;

  msh_ram #(.Width(32), .AddrBits(AW)) u_val (.clk(clk), .we(v_we), .waddr(v_wa),
    .wdata(v_wd), .raddr(v_ra), .rdata(v_rd));
  msh_ram #(.Width(AW), .AddrBits(AW)) u_ord (.clk(clk), .we(o_we), .waddr(o_wa),
    .wdata(o_wd), .raddr(o_ra), .rdata(o_rd));
  msh_ram #(.Width(AW), .AddrBits(AW)) u_pos (.clk(clk), .we(p_we), .waddr(p_wa),
    .wdata(p_wd), .raddr(p_ra), .rdata(p_rd));

  logic [AW-1:0] last;
  logic [CW:0] lc_w;
  assign last = AW'(count - CW'(1));
  assign lc_w = {1'b0, cur, 1'b1};

  assign in.ready = (state == S_IDLE);
  assign out.valid = (state == S_OUT);
  assign out.status = status;
  assign out.entry_total = 11'(count);
  assign out.is_empty = (count == '0);

  logic [AW-1:0] parent;
  assign parent = AW'((cur - AW'(1)) >> 1);

  // memory addressing per state
  always_comb begin
    v_we = 1'b0; o_we = 1'b0; p_we = 1'b0;
    v_wa = '0; o_wa = '0; p_wa = '0;
    v_wd = '0; o_wd = '0; p_wd = '0;
    v_ra = ent_cur; o_ra = cur; p_ra = last;
    unique case (state)
      S_IDLE: begin
        v_we = in.valid && in.operation == msh_pkg::OP_PUSH && count < CW'(msh_pkg::Depth);
        o_we = v_we; p_we = v_we;
        v_wa = AW'(count); o_wa = AW'(count); p_wa = AW'(count);
        v_wd = in.push_value; o_wd = AW'(count); p_wd = AW'(count);
        p_ra = last;
        o_ra = last;
      end
      S_POP_MOVE: begin
        o_we = 1'b1; o_wa = cur; o_wd = ent_oth;
        p_we = 1'b1; p_wa = ent_oth; p_wd = cur;
      end
      S_UP_RD: begin o_ra = cur; end
      S_UP_RDW: begin v_ra = o_rd; end
      S_UP_PV: begin o_ra = parent; end
      S_UP_PVW: begin v_ra = o_rd; end
      S_DN_RD: begin o_ra = cur; end
      S_DN_RDW: begin v_ra = o_rd; end
      S_DN_L: begin o_ra = lc; end
      S_DN_LW: begin v_ra = o_rd; end
      S_DN_R: begin o_ra = AW'(lc + AW'(1)); end
      S_DN_RW: begin v_ra = o_rd; end
      S_SWAP: begin
        o_we = 1'b1; o_wa = cur; o_wd = ent_oth;
        p_we = 1'b1; p_wa = ent_oth; p_wd = cur;
      end
      S_SWAP2: begin
        o_we = 1'b1; o_wa = oth; o_wd = ent_cur;
        p_we = 1'b1; p_wa = ent_cur; p_wd = oth;
      end
      S_FIN: begin v_ra = last; o_ra = '0; end
      S_FIN_W: begin v_ra = o_rd; end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      status <= msh_pkg::ST_OK;
      out.top_value <= '0;
      out.min_value <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in.valid) begin
            status <= msh_pkg::ST_OK;
            down_mode <= 1'b0;
            if (in.operation == msh_pkg::OP_PUSH) begin
              if (count >= CW'(msh_pkg::Depth)) begin
                status <= msh_pkg::ST_PUSH_FULL;
                state <= S_FIN;
              end else begin
                cur <= AW'(count);
                count <= count + CW'(1);
                state <= S_PUSH_W;
              end
            end else if (count == '0) begin
              status <= msh_pkg::ST_POP_EMPTY;
              state <= S_FIN;
            end else begin
              state <= S_POP_RDPOS;
            end
          end
        end
        S_PUSH_W: state <= S_UP_RD;
        // p_rd = slot of last entry, o_rd = entry in last heap slot
        S_POP_RDPOS: begin
          cur <= p_rd;
          ent_oth <= o_rd;
          count <= count - CW'(1);
          if (p_rd == last) state <= S_FIN;
          else state <= S_POP_MOVE;
        end
        S_POP_MOVE: begin
          down_mode <= 1'b1;
          moved_up <= 1'b0;
          state <= S_POP_MOVE2;
        end
        S_POP_MOVE2: state <= S_UP_RD;
        // sift up
        S_UP_RD: begin
          if (cur == '0) state <= (down_mode && !moved_up) ? S_DN_RD : S_FIN;
          else state <= S_UP_RDW;
        end
        S_UP_RDW: begin ent_cur <= o_rd; state <= S_UP_PV; end
        S_UP_PV: begin val_cur <= v_rd; state <= S_UP_PVW; end
        S_UP_PVW: begin ent_oth <= o_rd; oth <= parent; state <= S_UP_CMP; end
        S_UP_CMP: begin
          if ($signed(val_cur) < $signed(v_rd)) begin
            moved_up <= 1'b1;
            state <= S_SWAP;
          end else if (down_mode && !moved_up) begin
            state <= S_DN_RD;
          end else begin
            state <= S_FIN;
          end
        end
        // sift down
        S_DN_RD: begin
          lc <= AW'(lc_w);
          if (lc_w >= (CW+1)'(count)) state <= S_FIN;
          else state <= S_DN_RDW;
        end
        S_DN_RDW: begin ent_cur <= o_rd; state <= S_DN_L; end
        S_DN_L: begin
          val_cur <= v_rd; val_best <= v_rd; best <= cur; ent_best <= ent_cur;
          state <= S_DN_LW;
        end
        S_DN_LW: begin ent_oth <= o_rd; state <= S_DN_R; end
        S_DN_R: begin
          if ($signed(v_rd) < $signed(val_best)) begin
            val_best <= v_rd; best <= lc; ent_best <= ent_oth;
          end
          if ((CW)'(lc) + CW'(1) < count) state <= S_DN_RW;
          else state <= S_DN_CMP;
        end
        S_DN_RW: begin ent_oth <= o_rd; state <= S_DN_CMP; oth <= AW'(1); end
        S_DN_CMP: begin
          if (oth == AW'(1) && (CW)'(lc) + CW'(1) < count &&
              $signed(v_rd) < $signed(val_best)) begin
            oth <= AW'(lc + AW'(1)); ent_oth <= ent_oth; state <= S_SWAP;
          end else if (best != cur) begin
            oth <= best; ent_oth <= ent_best; state <= S_SWAP;
          end else begin
            state <= S_FIN;
          end
        end
        S_SWAP: state <= S_SWAP2;
        S_SWAP2: begin
          cur <= oth;
          if (moved_up || !down_mode) state <= S_UP_RD;
          else state <= S_DN_RD;
        end
        S_FIN: state <= S_FIN_W;
        S_FIN_W: begin
          out.top_value <= (count == '0) ? '0 : v_rd;
          state <= S_FIN2;
        end
        // v_rd holds the value of the entry in heap slot 0
        S_FIN2: begin
          out.min_value <= (count == '0) ? '0 : v_rd;
          state <= S_OUT;
        end
        S_OUT: if (out.ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
      if (state == S_DN_R) oth <= '0;
    end
  end
endmodule

FILE: tb/tb_min_stack_heap.sv
`timescale 1ns / 1ps

module tb_min_stack_heap;

  typedef struct packed {
    logic signed [31:0] top_value;
    logic signed [31:0] min_value;
    logic [10:0] entry_total;
    logic is_empty;
    logic [1:0] status;
  } stack_result_t;

  typedef struct {
    logic op;
    logic signed [31:0] value;
    logic known;
    stack_result_t res;
  } stim_row_t;

  logic clk;
  logic rst;
  int errors;
  stack_result_t pending_results[$];
  stim_row_t rows[$];

  // Predictor state
  logic signed [31:0] stk_val[msh_pkg::Depth];
  int heap_ent[msh_pkg::Depth];
  int heap_pos[msh_pkg::Depth];
  int n_entries;

  msh_in_if in_if (clk);
  msh_out_if out_if (clk);

  min_stack_heap uut (
    .clk(clk),
    .rst(rst),
    .in(in_if.sink),
    .out(out_if.source)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic logic signed [31:0] slot_val(int s);
    return stk_val[heap_ent[s]];
  endfunction

  function automatic void swap_slots(int a, int b);
    int t;
    t = heap_ent[a];
    heap_ent[a] = heap_ent[b];
    heap_ent[b] = t;
    heap_pos[heap_ent[a]] = a;
    heap_pos[heap_ent[b]] = b;
  endfunction

  function automatic int bubble_up(int i);
    int p;
    while (i > 0) begin
      p = (i - 1) / 2;
      if (!(slot_val(i) < slot_val(p))) break;
      swap_slots(i, p);
      i = p;
    end
    return i;
  endfunction

  function automatic void bubble_down(int i);
    int lc;
    int best;
    forever begin
      lc = 2 * i + 1;
      best = i;
      if (lc >= n_entries) break;
      if (slot_val(lc) < slot_val(best)) best = lc;
      if (lc + 1 < n_entries && slot_val(lc + 1) < slot_val(best)) best = lc + 1;
      if (best == i) break;
      swap_slots(i, best);
      i = best;
    end
  endfunction

  // Apply one operation to the shadow stack and return the expected result
  function automatic stack_result_t apply_stack_op(logic op, logic signed [31:0] v);
    stack_result_t r;
    int last;
    int pos;
    int k;
    r.status = msh_pkg::ST_OK;
    if (op == msh_pkg::OP_PUSH) begin
      if (n_entries >= msh_pkg::Depth) begin
        r.status = msh_pkg::ST_PUSH_FULL;
      end else begin
        k = n_entries;
        stk_val[k] = v;
        heap_ent[k] = k;
        heap_pos[k] = k;
        n_entries = k + 1;
        void'(bubble_up(k));
      end
    end else begin
      if (n_entries == 0) begin
        r.status = msh_pkg::ST_POP_EMPTY;
      end else begin
        last = n_entries - 1;
        pos = heap_pos[last];
        n_entries = last;
        if (pos != last) begin
          heap_ent[pos] = heap_ent[last];
          heap_pos[heap_ent[pos]] = pos;
          if (bubble_up(pos) == pos) bubble_down(pos);
        end
      end
    end
    if (n_entries > 0) begin
      r.top_value = stk_val[n_entries - 1];
      r.min_value = slot_val(0);
      r.is_empty = 1'b0;
    end else begin
      r.top_value = '0;
      r.min_value = '0;
      r.is_empty = 1'b1;
    end
    r.entry_total = n_entries[10:0];
    return r;
  endfunction

  task automatic report_mismatch(string field, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", field, got, want, $realtime);
    errors++;
  endtask

  task automatic add_row(logic op, logic signed [31:0] v, logic known = 1'b0,
                         logic signed [31:0] top = 0, logic signed [31:0] mn = 0,
                         int total = 0, logic [1:0] st = msh_pkg::ST_OK);
    stim_row_t r;
    r.op = op;
    r.value = v;
    r.known = known;
    r.res.top_value = top;
    r.res.min_value = mn;
    r.res.entry_total = total[10:0];
    r.res.is_empty = (total == 0);
    r.res.status = st;
    rows.push_back(r);
  endtask

  // Drive one transaction, optionally after an idle gap; valid stays high
  // after acceptance until a later call with a gap or an idle gap drops it
  task automatic send_op(logic op, logic signed [31:0] v, int gap);
    @(negedge clk);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_if.operation <= op;
    in_if.push_value <= v;
    in_if.valid <= 1'b1;
    do @(posedge clk); while (!in_if.ready);
    pending_results.push_back(apply_stack_op(op, v));
  endtask

  // Drop valid and hold it low through the requested idle gap
  task automatic idle_gap(int n);
    @(negedge clk);
    in_if.valid <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  // Receiver stall pattern
  initial begin
    int mode;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      mode = $urandom_range(0, 15);
      if (mode < 4) out_if.ready <= 1'b1;
      else if (mode < 6) out_if.ready <= 1'b0;
      else out_if.ready <= ($urandom_range(0, 3) != 0);
      if (mode == 0) repeat ($urandom_range(10, 40)) @(negedge clk);
    end
  end

  // Check each result transaction against the oldest expectation
  always @(posedge clk) begin
    stack_result_t want;
    if (!rst && out_if.valid && out_if.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", 1, 0);
      end else begin
        want = pending_results.pop_front();
        if (out_if.top_value !== want.top_value)
          report_mismatch("top_value", out_if.top_value, want.top_value);
        if (out_if.min_value !== want.min_value)
          report_mismatch("min_value", out_if.min_value, want.min_value);
        if (out_if.entry_total !== want.entry_total)
          report_mismatch("entry_total", out_if.entry_total, want.entry_total);
        if (out_if.is_empty !== want.is_empty)
          report_mismatch("is_empty", out_if.is_empty, want.is_empty);
        if (out_if.status !== want.status)
          report_mismatch("status", out_if.status, want.status);
      end
    end
  end

  initial begin
    int burst;
    int sent;
    int target;
    logic op;
    logic signed [31:0] v;
    errors = 0;
    n_entries = 0;
    rst = 1'b1;
    in_if.valid = 1'b0;
    in_if.operation = msh_pkg::OP_PUSH;
    in_if.push_value = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: empty pop, extremes, equal values, mid-heap removal
    add_row(msh_pkg::OP_POP, 32'sd5, 1'b1, 0, 0, 0, msh_pkg::ST_POP_EMPTY);
    add_row(msh_pkg::OP_PUSH, 32'h7FFF_FFFF, 1'b1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1);
    add_row(msh_pkg::OP_PUSH, 32'h8000_0000, 1'b1, 32'h8000_0000, 32'h8000_0000, 2);
    add_row(msh_pkg::OP_PUSH, 32'sd0, 1'b1, 0, 32'h8000_0000, 3);
    add_row(msh_pkg::OP_PUSH, -32'sd1);
    add_row(msh_pkg::OP_PUSH, 32'h8000_0000);
    add_row(msh_pkg::OP_PUSH, 32'sd7);
    add_row(msh_pkg::OP_PUSH, 32'sd7);
    add_row(msh_pkg::OP_POP, 32'hFFFF_FFFF);
    add_row(msh_pkg::OP_POP, 32'sd0);
    add_row(msh_pkg::OP_POP, 32'sd0);
    add_row(msh_pkg::OP_POP, 32'sd0);
    add_row(msh_pkg::OP_PUSH, 32'sh5555_5555);
    add_row(msh_pkg::OP_PUSH, 32'shAAAA_AAAA);
    add_row(msh_pkg::OP_POP, 32'sd0);
    add_row(msh_pkg::OP_POP, 32'sd0);
    add_row(msh_pkg::OP_POP, 32'sd0);
    add_row(msh_pkg::OP_POP, 32'sd0);
    add_row(msh_pkg::OP_POP, 32'sd0, 1'b1, 0, 0, 0, msh_pkg::ST_OK);
    add_row(msh_pkg::OP_POP, 32'sd0, 1'b1, 0, 0, 0, msh_pkg::ST_POP_EMPTY);
    foreach (rows[i]) begin
      send_op(rows[i].op, rows[i].value, $urandom_range(0, 2));
      if (rows[i].known && pending_results[$] != rows[i].res)
        report_mismatch("table row", i, -1);
    end

    // Random: short waves around small fill levels
    sent = 0;
    while (sent < 60) begin
      target = $urandom_range(0, 40);
      burst = $urandom_range(1, 12);
      while (burst > 0 && sent < 60) begin
        if ($urandom_range(0, 9) == 0) op = 1'($urandom_range(0, 1));
        else op = (n_entries < target) ? msh_pkg::OP_PUSH : msh_pkg::OP_POP;
        if ($urandom_range(0, 3) == 0) v = $signed(32'($urandom_range(0, 7))) - 32'sd4;
        else v = $urandom;
        send_op(op, v, 0);
        burst--;
        sent++;
      end
      idle_gap($urandom_range(0, 20));
    end

    // Fill to capacity in bursts to hit the full-push case
    while (n_entries < msh_pkg::Depth) begin
      if ($urandom_range(0, 3) == 0) v = $signed(32'($urandom_range(0, 7))) - 32'sd4;
      else v = $urandom;
      send_op(msh_pkg::OP_PUSH, v,
              ($urandom_range(0, 15) == 0) ? int'($urandom_range(1, 8)) : 0);
    end
    send_op(msh_pkg::OP_PUSH, 32'sd1, 0);
    send_op(msh_pkg::OP_PUSH, 32'sd2, 3);

    // Deep removals from a full heap, with a few pushes between
    repeat (20) begin
      op = ($urandom_range(0, 3) == 0) ? msh_pkg::OP_PUSH : msh_pkg::OP_POP;
      send_op(op, $urandom, $urandom_range(0, 2));
    end
    idle_gap(0);

    while (pending_results.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
